### sv/imtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imtm_pkg;

  localparam logic [4:0] MAC_LENGTH = 5'd17;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_IPV4 = 2'd1;
  localparam logic [1:0] KIND_MAC  = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } tok_t;

  typedef struct packed {
    logic       redact;
    logic [1:0] match_kind;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  // positions 2, 5, 8, 11, 14 carry a separator
  function automatic logic is_sep_pos(input logic [4:0] p);
    return (p == 5'd2) || (p == 5'd5) || (p == 5'd8) || (p == 5'd11) || (p == 5'd14);
  endfunction

endpackage

`default_nettype wire

### sv/imtm_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module imtm_scan
  import imtm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire tok_t       tok,
  output logic [1:0]      kind
);

  logic       ip_alive, ip_alive_next;
  logic [1:0] octet_index, octet_index_next;
  logic [1:0] octet_digits, octet_digits_next;
  logic [7:0] octet_value, octet_value_next;
  logic       octet_leading_zero, octet_leading_zero_next;
  logic       mac_alive, mac_alive_next;
  logic [4:0] mac_position, mac_position_next;

  logic [3:0]  digit;
  logic [11:0] grown;

  assign digit = 4'(tok.char_code - CHAR_ZERO);
  assign grown = 12'(octet_value) * 12'd10 + 12'(digit);

  always_comb begin
    ip_alive_next           = ip_alive;
    octet_index_next        = octet_index;
    octet_digits_next       = octet_digits;
    octet_value_next        = octet_value;
    octet_leading_zero_next = octet_leading_zero;
    if (ip_alive) begin
      if (is_digit(tok.char_code)) begin
        if (octet_digits == 2'd0) begin
          octet_leading_zero_next = (digit == 4'd0);
          octet_value_next        = 8'(digit);
          octet_digits_next       = 2'd1;
        end else if (octet_leading_zero || octet_digits == 2'd3) begin
          ip_alive_next = 1'b0;
        end else if (grown > 12'd255) begin
          ip_alive_next = 1'b0;
        end else begin
          octet_value_next  = grown[7:0];
          octet_digits_next = octet_digits + 2'd1;
        end
      end else if (tok.char_code == CHAR_DOT) begin
        if (octet_digits == 2'd0 || octet_index == 2'd3) begin
          ip_alive_next = 1'b0;
        end else begin
          octet_index_next        = octet_index + 2'd1;
          octet_digits_next       = 2'd0;
          octet_value_next        = 8'd0;
          octet_leading_zero_next = 1'b0;
        end
      end else begin
        ip_alive_next = 1'b0;
      end
    end
  end

  always_comb begin
    mac_alive_next    = mac_alive;
    mac_position_next = mac_position;
    if (mac_position >= MAC_LENGTH) begin
      mac_alive_next = 1'b0;
    end else begin
      if (is_sep_pos(mac_position)) begin
        if (tok.char_code != CHAR_COLON && tok.char_code != CHAR_DASH) begin
          mac_alive_next = 1'b0;
        end
      end else if (!is_hex(tok.char_code)) begin
        mac_alive_next = 1'b0;
      end
      mac_position_next = mac_position + 5'd1;
    end
  end

  always_comb begin
    if (ip_alive_next && octet_index_next == 2'd3 && octet_digits_next != 2'd0) begin
      kind = KIND_IPV4;
    end else if (mac_alive_next && mac_position_next == MAC_LENGTH) begin
      kind = KIND_MAC;
    end else begin
      kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && tok.is_last)) begin
      ip_alive           <= 1'b1;
      octet_index        <= 2'd0;
      octet_digits       <= 2'd0;
      octet_value        <= 8'd0;
      octet_leading_zero <= 1'b0;
      mac_alive          <= 1'b1;
      mac_position       <= 5'd0;
    end else if (step) begin
      ip_alive           <= ip_alive_next;
      octet_index        <= octet_index_next;
      octet_digits       <= octet_digits_next;
      octet_value        <= octet_value_next;
      octet_leading_zero <= octet_leading_zero_next;
      mac_alive          <= mac_alive_next;
      mac_position       <= mac_position_next;
    end
  end

endmodule

`default_nettype wire

### sv/ipv4_mac_token_matcher.sv
// ipv4_mac_token_matcher
// tokens stream in on the tok channel, one character per item, with is_last
// set on the final character of each token. each token yields exactly one
// item on the res channel: redact and match_kind (none, ipv4 or mac).
// characters other than the last produce no result.
// an accepted character lands in an input register; from there it updates the
// running scan state and, for a last character, loads the result register.
// a last character passes the input register and then the result register.
// throughput: one character per cycle while no last character is held back.
// when res_ready is low a pending result holds its register; non-final
// characters keep flowing, and a final character waits in the input
// register until the result register is free, which then backs up tok_ready.
// reset (rst, synchronous) empties both registers and returns the scan to
// the start of a token; the state also returns there after every last char.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_mac_token_matcher
  import imtm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic tok_valid,
  output logic      tok_ready,
  input  wire tok_t tok,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  logic       hold_valid;
  tok_t       hold;
  logic       advance;
  logic       res_free;
  logic [1:0] kind;

  assign res_free  = !res_valid || res_ready;
  assign advance   = hold_valid && (!hold.is_last || res_free);
  assign tok_ready = !hold_valid || advance;

  imtm_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .tok  (hold),
    .kind (kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (tok_ready) begin
        hold_valid <= tok_valid;
      end
      if (advance && hold.is_last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (tok_ready && tok_valid) begin
      hold <= tok;
    end
    if (advance && hold.is_last) begin
      res.redact     <= (kind != KIND_NONE);
      res.match_kind <= kind;
    end
  end

endmodule

`default_nettype wire

### sim/ipv4_mac_token_matcher_tb.sv
`timescale 1ns / 1ps

module ipv4_mac_token_matcher_tb;
  import imtm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tok_valid = 1'b0;
  logic tok_ready;
  tok_t tok = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  ipv4_mac_token_matcher i_dut (
    .clk(clk),
    .rst(rst),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok(tok),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  tok_t pending_chars[$];
  res_t expected_res[$];
  logic [7:0] word[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int chars_queued = 0;
  int send_rates[5] = '{0, 79, 0, 19, 0};
  int recv_rates[5] = '{0, 0, 79, 19, 0};

  // running scan state
  logic       ip_ok;
  logic [1:0] oct_idx;
  logic [1:0] oct_digits;
  logic [7:0] oct_val;
  logic       oct_lz;
  logic       mac_ok;
  logic [4:0] mac_pos;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic clear_scan();
    ip_ok = 1'b1;
    oct_idx = '0;
    oct_digits = '0;
    oct_val = '0;
    oct_lz = 1'b0;
    mac_ok = 1'b1;
    mac_pos = '0;
  endtask

  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  task automatic scan_char(input logic [7:0] c, input logic last);
    int   d;
    int   v;
    res_t r;
    if (ip_ok) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        d = int'(c - CHAR_ZERO);
        if (oct_digits == 2'd0) begin
          oct_lz = (d == 0);
          oct_val = 8'(d);
          oct_digits = 2'd1;
        end else if (oct_lz || oct_digits == 2'd3) begin
          ip_ok = 1'b0;
        end else begin
          v = int'(oct_val) * 10 + d;
          if (v > 255) begin
            ip_ok = 1'b0;
          end else begin
            oct_val = 8'(v);
            oct_digits = oct_digits + 2'd1;
          end
        end
      end else if (c == CHAR_DOT) begin
        if (oct_digits == 2'd0 || oct_idx == 2'd3) begin
          ip_ok = 1'b0;
        end else begin
          oct_idx = oct_idx + 2'd1;
          oct_digits = '0;
          oct_val = '0;
          oct_lz = 1'b0;
        end
      end else begin
        ip_ok = 1'b0;
      end
    end
    if (mac_pos >= MAC_LENGTH) begin
      mac_ok = 1'b0;
    end else begin
      if (mac_pos % 3 == 2) begin
        if (c != CHAR_COLON && c != CHAR_DASH) mac_ok = 1'b0;
      end else if (!hex_digit(c)) begin
        mac_ok = 1'b0;
      end
      mac_pos = mac_pos + 5'd1;
    end
    if (last) begin
      if (ip_ok && oct_idx == 2'd3 && oct_digits != 2'd0) r = '{1'b1, KIND_IPV4};
      else if (mac_ok && mac_pos == MAC_LENGTH) r = '{1'b1, KIND_MAC};
      else r = '{1'b0, KIND_NONE};
      expected_res.push_back(r);
      clear_scan();
    end
  endtask

  task automatic note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // token builders
  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) word.push_back(s[i]);
  endtask

  task automatic put_dec(input int v);
    put_str($sformatf("%0d", v));
  endtask

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((upper ? 8'h41 : 8'h61) + v - 10);
  endfunction

  task automatic put_hex_pair();
    repeat (2) word.push_back(hex_char($urandom_range(15), 1'($urandom_range(1))));
  endtask

  task automatic flush_word();
    for (int i = 0; i < word.size(); i++)
      pending_chars.push_back(tok_t'{word[i], (i == word.size() - 1)});
    chars_queued += word.size();
    word.delete();
  endtask

  task automatic gen_ipv4(input bit clean);
    int n;
    int r;
    n = 4;
    if (!clean && $urandom_range(3) == 0) n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put_str(".");
      r = clean ? $urandom_range(2) : $urandom_range(7);
      case (r)
        0: put_dec($urandom_range(9));
        1: put_dec($urandom_range(240, 255));
        2, 3: put_dec($urandom_range(255));
        4: begin
          put_str("0");
          put_dec($urandom_range(99));
        end
        5: put_dec($urandom_range(256, 999));
        6: put_dec($urandom_range(1000, 9999));
        default: ;
      endcase
    end
    if (!clean && $urandom_range(7) == 0) put_str(".");
  endtask

  task automatic gen_mac(input bit clean);
    int    n;
    string bad_seps;
    bad_seps = ". _;";
    n = clean ? 6 : $urandom_range(5, 7);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if (!clean && $urandom_range(7) == 0)
          word.push_back(bad_seps[$urandom_range(bad_seps.len() - 1)]);
        else
          word.push_back($urandom_range(1) ? CHAR_COLON : CHAR_DASH);
      end
      put_hex_pair();
    end
    if (!clean && $urandom_range(5) == 0) word.push_back(hex_char($urandom_range(15), 1'b0));
  endtask

  task automatic corrupt();
    int p;
    p = $urandom_range(word.size() - 1);
    case ($urandom_range(2))
      0: word[p] = 8'($urandom_range(255));
      1: if (word.size() > 1) word.delete(p);
      default: word.insert(p, 8'($urandom_range(255)));
    endcase
  endtask

  task automatic gen_noise();
    string charset;
    charset = "0123456789abcdefABCDEFgG.:-";
    repeat ($urandom_range(1, 20)) begin
      if ($urandom_range(1)) word.push_back(8'($urandom_range(255)));
      else word.push_back(charset[$urandom_range(charset.len() - 1)]);
    end
  endtask

  task automatic random_token();
    int r;
    r = $urandom_range(99);
    if (r < 30) gen_ipv4(1'b1);
    else if (r < 55) gen_mac(1'b1);
    else if (r < 68) gen_ipv4(1'b0);
    else if (r < 80) gen_mac(1'b0);
    else if (r < 90) begin
      if (r < 85) gen_ipv4(1'b1);
      else gen_mac(1'b1);
      corrupt();
    end else gen_noise();
    flush_word();
  endtask

  task automatic directed_tokens();
    put_str("0.0.0.0");
    flush_word();
    put_str("255.255.255.255");
    flush_word();
    put_str("aF-09:Bc-de:12:34");
    flush_word();
    word.push_back(8'h00);
    flush_word();
    word.push_back(8'hFF);
    flush_word();
    put_str("1.2.3.04");
    flush_word();
    put_str("256.1.1.1");
    flush_word();
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (!tok_valid || tok_ready) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tok <= pending_chars.pop_front();
        tok_valid <= 1'b1;
      end else begin
        tok_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (expected_res.size() == 0) begin
          note_fail($sformatf("unexpected result: redact=%0d kind=%0d",
                              res.redact, res.match_kind));
        end else begin
          want = expected_res.pop_front();
          if (res.redact !== want.redact || res.match_kind !== want.match_kind)
            note_fail($sformatf("mismatch: expected redact=%0d kind=%0d, got redact=%0d kind=%0d",
                                want.redact, want.match_kind, res.redact, res.match_kind));
        end
      end
      if (tok_valid && tok_ready) scan_char(tok.char_code, tok.is_last);
    end
  end

  initial begin
    clear_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      @(negedge clk);
      send_idle_pct = send_rates[ph];
      recv_stall_pct = recv_rates[ph];
      chars_queued = 0;
      if (ph == 0) directed_tokens();
      while (chars_queued < 240) random_token();
      // wait until the block has drained before the next phase
      while (pending_chars.size() != 0 || tok_valid || expected_res.size() != 0)
        @(posedge clk);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ipv4_mac_token_matcher] OK");
    end else begin
      $display("[ipv4_mac_token_matcher] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[ipv4_mac_token_matcher] ERROR");
    $finish;
  end

endmodule
